// ===== design/kdl_pkg.sv =====
package kdl_pkg;

  // Key count and code table
  localparam int MaxKeys  = 6;
  localparam int KeyCount = 6;           // 1 .. MaxKeys
  localparam int KeyW     = 3;           // key_index field width
  localparam int CodeW    = 8;
  localparam int TimeW    = 32;
  localparam int DebW     = 8;
  localparam int LimW     = 16;
  localparam int DataW    = 32;
  localparam int AddrW    = 4;

  localparam int ScanDepth = 2;
  localparam int ScanPtrW  = $clog2(ScanDepth);
  localparam int ScanCntW  = $clog2(ScanDepth + 1);
  localparam int OutDepth  = 4;
  localparam int OutPtrW   = $clog2(OutDepth);
  localparam int OutCntW   = $clog2(OutDepth + 1);

  typedef logic [CodeW-1:0] code_t;

  localparam code_t KeyCodes [MaxKeys] = '{
    code_t'(84), code_t'(92), code_t'(100), code_t'(108), code_t'(76), code_t'(68)
  };

  // Per-key phase, one-hot
  typedef enum logic [3:0] {
    PhIdle     = 4'b0001,
    PhDebounce = 4'b0010,
    PhPressed  = 4'b0100,
    PhLongWait = 4'b1000
  } phase_e;

  typedef enum logic [1:0] {
    EvPress  = 2'd0,
    EvShort  = 2'd1,
    EvLong   = 2'd2,
    EvRepeat = 2'd3
  } event_e;

  typedef enum logic [1:0] {
    RegDebounce = 2'd0,
    RegShort    = 2'd1,
    RegLong     = 2'd2
  } reg_e;

  // Back-end sequencer, one-hot
  typedef enum logic [2:0] {
    StIdle  = 3'b001,
    StWalk  = 3'b010,
    StFlush = 3'b100
  } walk_e;

  typedef struct packed {
    logic [CodeW-1:0] raw_key;
    logic [TimeW-1:0] now_ms;
  } in_word_t;

  typedef struct packed {
    logic [KeyW-1:0] key_index;
    logic [1:0]      event_code;
    logic            last_event;
  } out_word_t;

  typedef struct packed {
    logic [KeyCount-1:0] held;
    logic [TimeW-1:0]    now_ms;
  } scan_t;

  typedef struct packed {
    logic [DebW-1:0] debounce_scans;
    logic [LimW-1:0] short_limit_ms;
    logic [LimW-1:0] long_limit_ms;
  } cfg_t;

  // Front-to-back handshake
  typedef struct packed {
    logic  valid;
    scan_t scan;
  } scan_port_t;

  // Back-to-result-queue handshake
  typedef struct packed {
    logic      push;
    out_word_t word;
  } res_port_t;

endpackage

// ===== design/kdl_front.sv =====
module kdl_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  kdl_pkg::in_word_t   in_word_i,
  output logic                full_o,
  output kdl_pkg::scan_port_t scan_o,
  input  logic                scan_pop_i
);

  kdl_pkg::scan_t                  mem_q [kdl_pkg::ScanDepth];
  logic [kdl_pkg::ScanPtrW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [kdl_pkg::ScanCntW-1:0]    cnt_q, cnt_d;
  logic [kdl_pkg::KeyCount-1:0]    held;
  logic                            wr_en, rd_en;

  // key code decode: at most one flag set
  always_comb begin
    for (int k = 0; k < kdl_pkg::KeyCount; k++) begin
      held[k] = (in_word_i.raw_key == kdl_pkg::KeyCodes[k]);
    end
  end

  assign full_o = (cnt_q == kdl_pkg::ScanCntW'(kdl_pkg::ScanDepth));
  assign wr_en  = push_i && !full_o;
  assign rd_en  = scan_pop_i && (cnt_q != '0);

  assign scan_o.valid = (cnt_q != '0);
  assign scan_o.scan  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (wr_en) begin
      wr_d = (wr_q == kdl_pkg::ScanPtrW'(kdl_pkg::ScanDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (rd_en) begin
      rd_d = (rd_q == kdl_pkg::ScanPtrW'(kdl_pkg::ScanDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_q] <= '{held: held, now_ms: in_word_i.now_ms};
    end
  end

endmodule

// ===== design/kdl_back.sv =====
module kdl_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kdl_pkg::cfg_t       cfg_i,
  input  kdl_pkg::scan_port_t scan_i,
  output logic                scan_pop_o,
  input  logic                res_full_i,
  output kdl_pkg::res_port_t  res_o
);

  // per-key state
  kdl_pkg::phase_e              phase_q [kdl_pkg::KeyCount];
  logic [kdl_pkg::DebW-1:0]     cnt_q   [kdl_pkg::KeyCount];
  logic [kdl_pkg::TimeW-1:0]    start_q [kdl_pkg::KeyCount];
  logic                         long_q  [kdl_pkg::KeyCount];
  logic                         press_q [kdl_pkg::KeyCount];

  kdl_pkg::walk_e               state_q, state_d;
  logic [kdl_pkg::KeyW-1:0]     key_q, key_d;
  kdl_pkg::scan_t               scan_q;
  logic                         pend_vld_q, pend_vld_d;
  logic [kdl_pkg::KeyW-1:0]     pend_key_q, pend_key_d;
  kdl_pkg::event_e              pend_ev_q, pend_ev_d;

  kdl_pkg::phase_e              ph, nph;
  logic [kdl_pkg::DebW-1:0]     cnt, cnt_inc, ncnt;
  logic [kdl_pkg::TimeW-1:0]    dur, nstart;
  logic                         nlong, npress, held, ev_vld, step_en, last_key;
  kdl_pkg::event_e              ev;

  assign ph       = phase_q[key_q];
  assign cnt      = cnt_q[key_q];
  assign held     = scan_q.held[key_q];
  assign dur      = scan_q.now_ms - start_q[key_q];
  assign cnt_inc  = (cnt == '1) ? cnt : cnt + 1'b1;
  assign step_en  = (state_q == kdl_pkg::StWalk) && !res_full_i;
  assign last_key = (key_q == kdl_pkg::KeyW'(kdl_pkg::KeyCount - 1));

  // one key step
  always_comb begin
    nph    = ph;
    ncnt   = cnt;
    nstart = start_q[key_q];
    nlong  = long_q[key_q];
    npress = press_q[key_q];
    ev_vld = 1'b0;
    ev     = kdl_pkg::EvPress;
    case (ph)
      kdl_pkg::PhIdle: begin
        if (held) begin
          nph  = kdl_pkg::PhDebounce;
          ncnt = '0;
        end
      end
      kdl_pkg::PhDebounce: begin
        if (held) begin
          ncnt = cnt_inc;
          if (cnt_inc >= cfg_i.debounce_scans) begin
            nph    = kdl_pkg::PhPressed;
            nstart = scan_q.now_ms;
            nlong  = 1'b0;
            npress = 1'b0;
          end
        end else begin
          nph = kdl_pkg::PhIdle;
        end
      end
      kdl_pkg::PhPressed: begin
        if (!held) begin
          if (dur <= kdl_pkg::TimeW'(cfg_i.short_limit_ms)) begin
            ev_vld = 1'b1;
            ev     = kdl_pkg::EvShort;
          end
          nph = kdl_pkg::PhIdle;
        end else begin
          if (dur > kdl_pkg::TimeW'(cfg_i.short_limit_ms)) begin
            nph = kdl_pkg::PhLongWait;
          end
          if (!press_q[key_q]) begin
            npress = 1'b1;
            ev_vld = 1'b1;
            ev     = kdl_pkg::EvPress;
          end
        end
      end
      default: begin
        if (!held) begin
          nph = kdl_pkg::PhIdle;
        end else if (dur >= kdl_pkg::TimeW'(cfg_i.long_limit_ms)) begin
          ev_vld = 1'b1;
          if (!long_q[key_q]) begin
            nlong = 1'b1;
            ev    = kdl_pkg::EvLong;
          end else begin
            ev = kdl_pkg::EvRepeat;
          end
        end
      end
    endcase
  end

  // sequencer; one event waits for the next one or scan end, which sets last_event
  always_comb begin
    state_d    = state_q;
    key_d      = key_q;
    pend_vld_d = pend_vld_q;
    pend_key_d = pend_key_q;
    pend_ev_d  = pend_ev_q;
    scan_pop_o = 1'b0;
    res_o.push = 1'b0;
    res_o.word = '{key_index: pend_key_q, event_code: pend_ev_q, last_event: 1'b0};
    case (state_q)
      kdl_pkg::StIdle: begin
        if (scan_i.valid) begin
          scan_pop_o = 1'b1;
          key_d      = '0;
          state_d    = kdl_pkg::StWalk;
        end
      end
      kdl_pkg::StWalk: begin
        if (step_en) begin
          if (ev_vld) begin
            res_o.push = pend_vld_q;
            pend_vld_d = 1'b1;
            pend_key_d = key_q;
            pend_ev_d  = ev;
          end
          if (last_key) begin
            state_d = kdl_pkg::StFlush;
          end else begin
            key_d = key_q + 1'b1;
          end
        end
      end
      kdl_pkg::StFlush: begin
        res_o.word.last_event = 1'b1;
        if (!pend_vld_q) begin
          state_d = kdl_pkg::StIdle;
        end else if (!res_full_i) begin
          res_o.push = 1'b1;
          pend_vld_d = 1'b0;
          state_d    = kdl_pkg::StIdle;
        end
      end
      default: begin
        state_d = kdl_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= kdl_pkg::StIdle;
      key_q      <= '0;
      pend_vld_q <= 1'b0;
      for (int k = 0; k < kdl_pkg::KeyCount; k++) begin
        phase_q[k] <= kdl_pkg::PhIdle;
        long_q[k]  <= 1'b0;
        press_q[k] <= 1'b0;
        cnt_q[k]   <= '0;
        start_q[k] <= '0;
      end
    end else begin
      state_q    <= state_d;
      key_q      <= key_d;
      pend_vld_q <= pend_vld_d;
      if (step_en) begin
        phase_q[key_q] <= nph;
        cnt_q[key_q]   <= ncnt;
        start_q[key_q] <= nstart;
        long_q[key_q]  <= nlong;
        press_q[key_q] <= npress;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_key_q <= pend_key_d;
    pend_ev_q  <= pend_ev_d;
    if (scan_pop_o) begin
      scan_q <= scan_i.scan;
    end
  end

endmodule

// ===== design/kdl_outq.sv =====
module kdl_outq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kdl_pkg::res_port_t  res_i,
  output logic                full_o,
  output logic                empty_o,
  input  logic                pop_i,
  output kdl_pkg::out_word_t  out_word_o
);

  kdl_pkg::out_word_t           mem_q [kdl_pkg::OutDepth];
  logic [kdl_pkg::OutPtrW-1:0]  wr_q, rd_q;
  logic [kdl_pkg::OutCntW-1:0]  cnt_q;
  logic                         wr_en, rd_en;

  assign full_o     = (cnt_q == kdl_pkg::OutCntW'(kdl_pkg::OutDepth));
  assign empty_o    = (cnt_q == '0);
  assign wr_en      = res_i.push && !full_o;
  assign rd_en      = pop_i && !empty_o;
  assign out_word_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_en) begin
        wr_q <= (wr_q == kdl_pkg::OutPtrW'(kdl_pkg::OutDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (rd_en) begin
        rd_q <= (rd_q == kdl_pkg::OutPtrW'(kdl_pkg::OutDepth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (wr_en && !rd_en) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (rd_en && !wr_en) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_q] <= res_i.word;
    end
  end

endmodule

// ===== design/key_debounce_long_press_events.sv =====
// Channel   Direction  Handshake                 Word
// scan in   input      push / full               in_word_i  (raw_key, now_ms)
// events    output     pop / empty               out_word_o (key_index, event_code, last_event)
// config    input      APB psel/penable/pwrite   paddr[3:2] picks the register, pwdata
//
// In the back end a scan is loaded, then walked key by key (six keys) through the shared
// key-step logic, then the held-back last event is flushed.
// A 2-deep scan queue in front lets the next scans come in while one is walked.
// A full 4-deep event queue stalls the key walk; the front keeps taking scans until
// its own queue fills.
// Reset clears all key state and queues at once; registers come up at 3 / 1000 / 2000.
module key_debounce_long_press_events (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // scan words
  input  logic                                push,
  output logic                                full,
  input  kdl_pkg::in_word_t                   in_word_i,
  // event words
  output logic                                empty,
  input  logic                                pop,
  output kdl_pkg::out_word_t                  out_word_o,
  // config
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [kdl_pkg::AddrW-1:0]           paddr,
  input  logic [kdl_pkg::DataW-1:0]           pwdata,
  output logic [kdl_pkg::DataW-1:0]           prdata,
  output logic                                pready
);

  kdl_pkg::cfg_t       cfg_q;
  kdl_pkg::scan_port_t scan;
  kdl_pkg::res_port_t  res;
  logic                scan_pop;
  logic                res_full;
  logic                cfg_wr;
  kdl_pkg::reg_e       reg_sel;

  // --- configuration registers -------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = kdl_pkg::reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_scans <= kdl_pkg::DebW'(3);
      cfg_q.short_limit_ms <= kdl_pkg::LimW'(1000);
      cfg_q.long_limit_ms  <= kdl_pkg::LimW'(2000);
    end else if (cfg_wr) begin
      case (reg_sel)
        kdl_pkg::RegDebounce: cfg_q.debounce_scans <= pwdata[kdl_pkg::DebW-1:0];
        kdl_pkg::RegShort:    cfg_q.short_limit_ms <= pwdata[kdl_pkg::LimW-1:0];
        kdl_pkg::RegLong:     cfg_q.long_limit_ms  <= pwdata[kdl_pkg::LimW-1:0];
        default: ;  // unmapped: ignored
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      kdl_pkg::RegDebounce: prdata = kdl_pkg::DataW'(cfg_q.debounce_scans);
      kdl_pkg::RegShort:    prdata = kdl_pkg::DataW'(cfg_q.short_limit_ms);
      kdl_pkg::RegLong:     prdata = kdl_pkg::DataW'(cfg_q.long_limit_ms);
      default:              prdata = '0;
    endcase
  end

  // --- front: decode raw code into held flags, queue the scan ------------
  kdl_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .in_word_i  (in_word_i),
    .full_o     (full),
    .scan_o     (scan),
    .scan_pop_i (scan_pop)
  );

  // --- back: walk the keys one per cycle while the event queue is not full, build events
  kdl_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .scan_i     (scan),
    .scan_pop_o (scan_pop),
    .res_full_i (res_full),
    .res_o      (res)
  );

  // --- event queue to the consumer ---------------------------------------
  kdl_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_i      (res),
    .full_o     (res_full),
    .empty_o    (empty),
    .pop_i      (pop),
    .out_word_o (out_word_o)
  );

endmodule

// ===== design/kdl_checker.sv =====
module kdl_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      full,
  input logic                      empty,
  input logic                      pop,
  input kdl_pkg::out_word_t        out_word_o,
  input logic                      psel,
  input logic                      penable,
  input logic                      pwrite,
  input logic [kdl_pkg::AddrW-1:0] paddr,
  input logic [kdl_pkg::DataW-1:0] pwdata,
  input logic [kdl_pkg::DataW-1:0] prdata
);

  // waiting event word holds until popped
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_word_o)))
    else $error("event word changed while stalled");

  // events only name existing keys
  a_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_word_o.key_index < kdl_pkg::KeyW'(kdl_pkg::KeyCount)))
    else $error("event for nonexistent key");

  // debounce register reads back what was written
  a_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((psel && penable && pwrite && paddr[3:2] == kdl_pkg::RegDebounce) ##1
     (psel && !pwrite && paddr[3:2] == kdl_pkg::RegDebounce))
    |-> (prdata == kdl_pkg::DataW'($past(pwdata[kdl_pkg::DebW-1:0]))))
    else $error("debounce register readback mismatch");

  // queues come out of reset empty
  a_rst: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> (empty && !full))
    else $error("queues not empty after reset");

endmodule

bind key_debounce_long_press_events kdl_checker u_kdl_checker (.*);
